// ===== rtl/tofm_pkg.sv =====
`timescale 1ns / 1ps
package tofm_pkg;

  localparam int TILE_SIZE_DEF   = 32;
  localparam int MAX_TILES_X_DEF = 128;
  localparam int MAX_TILES_Y_DEF = 128;
  localparam int NO_FLOOR_DEF    = 255;

  localparam int unsigned GATE_MIN_SCORE     = 32;
  localparam int unsigned GATE_LARGE_AREA    = 1024 * 1024;
  localparam int unsigned GATE_LARGE_WINDOWS = 4;
  localparam int unsigned GATE_MIN_WINDOWS   = 2;

  typedef enum logic [2:0] {
    ACT_FRAME  = 3'd0,
    ACT_DAMAGE = 3'd1,
    ACT_GATE   = 3'd2,
    ACT_WINDOW = 3'd3,
    ACT_FINISH = 3'd4,
    ACT_QUERY  = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    REG_DISP_W   = 3'd0,
    REG_DISP_H   = 3'd1,
    REG_COLS     = 3'd2,
    REG_ROWS     = 3'd3,
    REG_RADIUS   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         win_count;
    logic [15:0]        rect_x0;
    logic [15:0]        rect_y0;
    logic [15:0]        rect_x1;
    logic [15:0]        rect_y1;
    logic signed [15:0] win_x;
    logic signed [15:0] win_y;
    logic [15:0]        win_width;
    logic [15:0]        win_height;
    logic [7:0]         layer;
    logic               visible;
  } in_item_t;

  typedef struct packed {
    logic       floor_found;
    logic [7:0] floor_layer;
    logic       map_valid;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [12:0] data;
  } cfg_item_t;

endpackage

// ===== rtl/tofm_tile_ram.sv =====
`timescale 1ns / 1ps
module tofm_tile_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/tile_occlusion_floor_map.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid/in_ready   | tofm_pkg::in_item_t
// out     | out | out_valid/out_ready | tofm_pkg::out_item_t
// cfg     | in  | cfg_valid/cfg_ready | tofm_pkg::cfg_item_t
//
// An input transfer is taken only in idle; the item then runs through its states in turn:
// frame, finish, unused codes and items rejected up front go straight to done; damage adds
// a step for the registered 16x16 multiply, then the saturating add; gate, when it fires,
// clears the area in use, one tile per cycle; window walks its covered tiles; query the tiles visited.
// Reset is synchronous; tile memory is not cleared (gate clears the area in use).
// The done step waits while the output register holds a result not yet taken.
module tile_occlusion_floor_map #(
  parameter int MAX_TILES_X = tofm_pkg::MAX_TILES_X_DEF,
  parameter int MAX_TILES_Y = tofm_pkg::MAX_TILES_Y_DEF,
  parameter int NO_FLOOR    = tofm_pkg::NO_FLOOR_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tofm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tofm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  tofm_pkg::cfg_item_t cfg_data
);
  localparam int XW    = $clog2(MAX_TILES_X + 1);
  localparam int YW    = $clog2(MAX_TILES_Y + 1);
  localparam int DEPTH = MAX_TILES_X * MAX_TILES_Y;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TS    = $clog2(tofm_pkg::TILE_SIZE_DEF);
  localparam logic [7:0] NOF = 8'(NO_FLOOR);
  localparam logic [1:0] MODE_FILL  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DMG   = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_RANGE = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  tofm_pkg::in_item_t item;

  logic [12:0] disp_w, disp_h;
  logic [7:0]  tile_cols, tile_rows, radius;
  logic        map_is_valid, building;
  logic [7:0]  frame_windows;
  logic [15:0] damage_total;
  logic [35:0] damage_area;
  logic [31:0] prod;

  // walk bounds and cursor
  logic [XW-1:0] fx, lx, cx;
  logic [YW-1:0] ly, cy;
  logic [1:0]    mode;       // fill or query
  logic [7:0]    fill_val;
  logic [8:0]    best;
  logic          ok, rd_pend;

  logic [XW-1:0] cols;
  logic [YW-1:0] rows;
  logic [XW-1:0] mx_x;
  logic [YW-1:0] mx_y;

  assign mx_x = XW'(MAX_TILES_X);
  assign mx_y = YW'(MAX_TILES_Y);
  assign cols = (10'(tile_cols) > 10'(MAX_TILES_X)) ? mx_x : XW'(tile_cols);
  assign rows = (10'(tile_rows) > 10'(MAX_TILES_Y)) ? mx_y : YW'(tile_rows);

  // config
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_w    <= 13'd1024;
      disp_h    <= 13'd768;
      tile_cols <= 8'd32;
      tile_rows <= 8'd24;
      radius    <= 8'd8;
    end else if (cfg_valid) begin
      case (cfg_data.index)
        tofm_pkg::REG_DISP_W: disp_w    <= cfg_data.data;
        tofm_pkg::REG_DISP_H: disp_h    <= cfg_data.data;
        tofm_pkg::REG_COLS:   tile_cols <= cfg_data.data[7:0];
        tofm_pkg::REG_ROWS:   tile_rows <= cfg_data.data[7:0];
        tofm_pkg::REG_RADIUS: radius    <= cfg_data.data[7:0];
        default: ;
      endcase
    end
  end

  // covered range on one axis, combinational from registered item
  // packs {first, last} as two 16-bit halves
  function automatic logic [31:0] cov(input logic signed [18:0] s_in,
                                      input logic signed [18:0] e_in,
                                      input logic [12:0] ext,
                                      input logic [15:0] cnt);
    logic signed [18:0] s, e;
    logic [18:0] b, f;
    begin
      s = s_in; e = e_in;
      if (ext == 13'd0 || cnt == 16'd0 || s >= e || e <= 0 || s >= $signed({6'd0, ext}))
        cov = '0;
      else begin
        if (s < 0) s = '0;
        if (e > $signed({6'd0, ext})) e = $signed({6'd0, ext});
        b = 19'((19'(s) + 19'(tofm_pkg::TILE_SIZE_DEF - 1)) >> TS);
        if (e == $signed({6'd0, ext})) f = 19'(cnt);
        else f = 19'(19'(e) >> TS);
        if (b > 19'(cnt)) b = 19'(cnt);
        if (f > 19'(cnt)) f = 19'(cnt);
        if (f < b) f = b;
        cov = {b[15:0], f[15:0]};
      end
    end
  endfunction

  logic signed [18:0] xs, xe, ys, ye;
  logic [31:0] rx, ry;
  assign xs = 19'(item.win_x) + $signed({11'd0, radius});
  assign xe = 19'(item.win_x) + $signed({3'd0, item.win_width}) - $signed({11'd0, radius});
  assign ys = 19'(item.win_y) + $signed({11'd0, radius});
  assign ye = 19'(item.win_y) + $signed({3'd0, item.win_height}) - $signed({11'd0, radius});
  assign rx = cov(xs, xe, disp_w, 16'(cols));
  assign ry = cov(ys, ye, disp_h, 16'(rows));

  // memory
  logic          we;
  logic [AW-1:0] addr, waddr;
  logic [7:0]    rdata;
  assign addr = AW'(32'(cy) * MAX_TILES_X + 32'(cx));
  assign waddr = addr;
  assign we = (state == S_WALK) && (mode == MODE_FILL);

  tofm_tile_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(fill_val), .raddr(addr), .rdata(rdata)
  );

  // output register; a held result only stalls the done step
  logic out_full, res_load;
  assign out_valid = out_full;
  assign in_ready = (state == S_IDLE);
  assign res_load = (state == S_DONE) && (!out_full || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_load) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  logic [15:0] dx, dy;
  logic        rect_ok;
  assign rect_ok = (item.rect_x0 < item.rect_x1) && (item.rect_y0 < item.rect_y1);
  assign dx = item.rect_x1 - item.rect_x0;
  assign dy = item.rect_y1 - item.rect_y0;

  logic [23:0] score;
  assign score = frame_windows * damage_total;
  logic fire;
  assign fire = (frame_windows >= 8'(tofm_pkg::GATE_MIN_WINDOWS)) && (damage_total != 0)
             && (cols != 0) && (rows != 0)
             && ((score >= 24'(tofm_pkg::GATE_MIN_SCORE))
                 || ((damage_area >= 36'(tofm_pkg::GATE_LARGE_AREA))
                     && (frame_windows >= 8'(tofm_pkg::GATE_LARGE_WINDOWS))));

  logic [16:0] r2;
  assign r2 = {8'd0, radius, 1'b0};

  logic [16:0] qfx, qlx, qfy, qly;
  assign qfx = 17'(item.rect_x0 >> TS);
  assign qfy = 17'(item.rect_y0 >> TS);
  assign qlx = 17'((item.rect_x1 - 16'd1) >> TS);
  assign qly = 17'((item.rect_y1 - 16'd1) >> TS);

  logic last_tile;
  assign last_tile = (cx + 1'b1 == lx) && (cy + 1'b1 == ly);

  // tile read back during a query is unusable
  logic rd_bad;
  assign rd_bad = (rdata == NOF) || (rdata >= frame_windows);

  logic [36:0] asum;
  assign asum = {1'b0, damage_area} + 37'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      map_is_valid <= 1'b0;
      building <= 1'b0;
      frame_windows <= '0;
      damage_total <= '0;
      damage_area <= '0;
      rd_pend <= 1'b0;
      mode <= MODE_FILL;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_DONE;
          case (item.action)
            tofm_pkg::ACT_FRAME: begin
              frame_windows <= item.win_count;
              map_is_valid <= 1'b0; building <= 1'b0;
              damage_total <= '0; damage_area <= '0;
            end
            tofm_pkg::ACT_DAMAGE: begin
              if (damage_total != 16'hFFFF) damage_total <= damage_total + 1'b1;
              prod <= rect_ok ? dx * dy : '0;
              state <= S_DMG;
            end
            tofm_pkg::ACT_GATE: begin
              map_is_valid <= 1'b0;
              building <= fire;
              if (fire) begin
                mode <= MODE_FILL; fill_val <= NOF;
                fx <= '0; lx <= cols; ly <= rows;
                cx <= '0; cy <= '0;
                state <= S_WALK;
              end
            end
            tofm_pkg::ACT_WINDOW: begin
              if (building && item.visible && item.layer < NOF
                  && {1'b0, item.win_width} > r2 && {1'b0, item.win_height} > r2)
                state <= S_RANGE;
            end
            tofm_pkg::ACT_FINISH: begin
              if (building) begin
                map_is_valid <= 1'b1; building <= 1'b0;
              end
            end
            tofm_pkg::ACT_QUERY: begin
              if (map_is_valid && rect_ok && cols != 0 && rows != 0
                  && qfx < 17'(cols) && qfy < 17'(rows)) begin
                mode <= MODE_QUERY;
                fx <= XW'(qfx);
                cx <= XW'(qfx); cy <= YW'(qfy);
                lx <= (qlx >= 17'(cols)) ? cols : XW'(qlx + 17'd1);
                ly <= (qly >= 17'(rows)) ? rows : YW'(qly + 17'd1);
                best <= 9'h100; ok <= 1'b1;
                state <= S_WALK;
              end
            end
            default: ;
          endcase
        end
        S_DMG: begin
          damage_area <= asum[36] ? '1 : asum[35:0];
          state <= S_DONE;
        end
        S_RANGE: begin
          if (rx[31:16] < rx[15:0] && ry[31:16] < ry[15:0]) begin
            mode <= MODE_FILL; fill_val <= item.layer;
            fx <= XW'(rx[31:16]); lx <= XW'(rx[15:0]);
            ly <= YW'(ry[15:0]);
            cx <= XW'(rx[31:16]); cy <= YW'(ry[31:16]);
            state <= S_WALK;
          end else begin
            state <= S_DONE;
          end
        end
        S_WALK: begin
          if (rd_pend) begin
            if (rd_bad) ok <= 1'b0;
            else if ({1'b0, rdata} < best) best <= {1'b0, rdata};
          end
          if (rd_pend && rd_bad) begin
            rd_pend <= 1'b0;
            state <= S_DONE;
          end else begin
            rd_pend <= (mode == MODE_QUERY);
            if (last_tile) begin
              state <= (mode == MODE_QUERY) ? S_DRAIN : S_DONE;
            end else if (cx + 1'b1 == lx) begin
              cx <= fx; cy <= cy + 1'b1;
            end else begin
              cx <= cx + 1'b1;
            end
          end
        end
        S_DRAIN: begin
          rd_pend <= 1'b0;
          if (rd_bad) ok <= 1'b0;
          else if ({1'b0, rdata} < best) best <= {1'b0, rdata};
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            out_data.map_valid <= map_is_valid;
            if (item.action == tofm_pkg::ACT_QUERY && mode == MODE_QUERY && ok
                && best[8] == 1'b0) begin
              out_data.floor_found <= 1'b1;
              out_data.floor_layer <= best[7:0];
            end else begin
              out_data.floor_found <= 1'b0;
              out_data.floor_layer <= '0;
            end
            mode <= MODE_FILL;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_done_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.floor_found) |-> out_data.map_valid) else $error("floor w/o map");
  a_walk_bounds: assert property (@(posedge clk) disable iff (rst)
    we |-> (cx < lx) && (cy < ly)) else $error("write outside walk");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_data)) else $error("result changed");
endmodule

// ===== dv/tb_tile_occlusion_floor_map.sv =====
`timescale 1ns / 1ps
module tb_tile_occlusion_floor_map;
  import tofm_pkg::*;

  // Tracks the expected answer for every transfer on the input channel.
  // It keeps its own copy of the tile map, the frame counters and the registers.
  class floor_map_scoreboard;
    int unsigned disp_w, disp_h, cols_reg, rows_reg, radius;
    byte unsigned tile_map[MAX_TILES_X_DEF * MAX_TILES_Y_DEF];
    bit map_ok, building;
    int unsigned frame_win, dmg_count;
    longint unsigned dmg_area;
    out_item_t awaited[$];
    int errors;

    function new();
      disp_w = 1024;
      disp_h = 768;
      cols_reg = 32;
      rows_reg = 24;
      radius = 8;
      map_ok = 0;
      building = 0;
      frame_win = 0;
      dmg_count = 0;
      dmg_area = 0;
      errors = 0;
    endfunction

    function void write_reg(reg_index_t idx, int unsigned v);
      case (idx)
        REG_DISP_W: disp_w = v & 13'h1fff;
        REG_DISP_H: disp_h = v & 13'h1fff;
        REG_COLS:   cols_reg = v & 8'hff;
        REG_ROWS:   rows_reg = v & 8'hff;
        REG_RADIUS: radius = v & 8'hff;
        default: ;
      endcase
    endfunction

    // Tiles wholly inside [s, e) on one axis; the display-edge tile counts as covered.
    function void tile_span(longint s, longint e, int unsigned ext, int unsigned cnt,
                            output int unsigned first, output int unsigned last);
      int unsigned b, f;
      first = 0;
      last = 0;
      if (ext == 0 || cnt == 0 || s >= e || e <= 0 || s >= longint'(ext)) return;
      if (s < 0) s = 0;
      if (e > longint'(ext)) e = ext;
      b = int'((s + TILE_SIZE_DEF - 1) / TILE_SIZE_DEF);
      f = (e == longint'(ext)) ? cnt : int'(e / TILE_SIZE_DEF);
      if (b > cnt) b = cnt;
      if (f > cnt) f = cnt;
      if (f < b) f = b;
      first = b;
      last = f;
    endfunction

    function void note_request(in_item_t it);
      out_item_t res;
      int unsigned cols, rows, fx, lx, fy, ly, best, cell_val;
      longint wx, wy, r;
      bit fire, ok;
      cols = (cols_reg > MAX_TILES_X_DEF) ? MAX_TILES_X_DEF : cols_reg;
      rows = (rows_reg > MAX_TILES_Y_DEF) ? MAX_TILES_Y_DEF : rows_reg;
      res = '0;
      case (action_t'(it.action))
        ACT_FRAME: begin
          frame_win = it.win_count;
          map_ok = 0;
          building = 0;
          dmg_count = 0;
          dmg_area = 0;
        end
        ACT_DAMAGE: begin
          if (dmg_count < 16'hffff) dmg_count++;
          if (it.rect_x0 < it.rect_x1 && it.rect_y0 < it.rect_y1) begin
            dmg_area += longint'(it.rect_x1 - it.rect_x0) * longint'(it.rect_y1 - it.rect_y0);
            if (dmg_area > 64'hf_ffff_ffff) dmg_area = 64'hf_ffff_ffff;
          end
        end
        ACT_GATE: begin
          fire = 0;
          map_ok = 0;
          if (frame_win >= GATE_MIN_WINDOWS && dmg_count != 0 && cols != 0 && rows != 0) begin
            if (frame_win * dmg_count >= GATE_MIN_SCORE ||
                (dmg_area >= GATE_LARGE_AREA && frame_win >= GATE_LARGE_WINDOWS))
              fire = 1;
          end
          building = fire;
          if (fire)
            for (int ty = 0; ty < rows; ty++)
              for (int tx = 0; tx < cols; tx++)
                tile_map[ty * MAX_TILES_X_DEF + tx] = 8'(NO_FLOOR_DEF);
        end
        ACT_WINDOW: begin
          r = radius;
          if (building && it.visible && it.layer < NO_FLOOR_DEF &&
              it.win_width > 2 * r && it.win_height > 2 * r) begin
            wx = $signed(it.win_x);
            wy = $signed(it.win_y);
            tile_span(wx + r, wx + longint'(it.win_width) - r, disp_w, cols, fx, lx);
            tile_span(wy + r, wy + longint'(it.win_height) - r, disp_h, rows, fy, ly);
            if (fx < lx && fy < ly)
              for (int ty = fy; ty < ly; ty++)
                for (int tx = fx; tx < lx; tx++)
                  tile_map[ty * MAX_TILES_X_DEF + tx] = it.layer;
          end
        end
        ACT_FINISH: begin
          if (building) begin
            map_ok = 1;
            building = 0;
          end
        end
        ACT_QUERY: begin
          if (map_ok && it.rect_x0 < it.rect_x1 && it.rect_y0 < it.rect_y1 &&
              cols != 0 && rows != 0) begin
            fx = it.rect_x0 / TILE_SIZE_DEF;
            lx = (it.rect_x1 - 1) / TILE_SIZE_DEF;
            fy = it.rect_y0 / TILE_SIZE_DEF;
            ly = (it.rect_y1 - 1) / TILE_SIZE_DEF;
            if (fx < cols && fy < rows) begin
              best = 256;
              ok = 1;
              if (lx >= cols) lx = cols - 1;
              if (ly >= rows) ly = rows - 1;
              for (int ty = fy; ok && ty <= ly; ty++)
                for (int tx = fx; ok && tx <= lx; tx++) begin
                  cell_val = tile_map[ty * MAX_TILES_X_DEF + tx];
                  if (cell_val == NO_FLOOR_DEF || cell_val >= frame_win) ok = 0;
                  else if (cell_val < best) best = cell_val;
                end
              if (ok && best <= 255) begin
                res.floor_found = 1;
                res.floor_layer = 8'(best);
              end
            end
          end
        end
        default: ;
      endcase
      res.map_valid = map_ok;
      awaited.push_back(res);
    endfunction

    function void check_answer(out_item_t got);
      out_item_t exp_res;
      if (awaited.size() == 0) begin
        $error("result with nothing outstanding: %p", got);
        errors++;
        return;
      end
      exp_res = awaited.pop_front();
      if (got.floor_found !== exp_res.floor_found) begin
        $error("floor_found expected %0d got %0d", exp_res.floor_found, got.floor_found);
        errors++;
      end
      if (got.floor_layer !== exp_res.floor_layer) begin
        $error("floor_layer expected %0d got %0d", exp_res.floor_layer, got.floor_layer);
        errors++;
      end
      if (got.map_valid !== exp_res.map_valid) begin
        $error("map_valid expected %0d got %0d", exp_res.map_valid, got.map_valid);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  cfg_item_t cfg_data;

  floor_map_scoreboard sb;
  int burst_left = 0;
  int unsigned rx_cycle = 0;
  int sent = 0;

  always #5 clk = ~clk;

  tile_occlusion_floor_map dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Receiver: checks each transfer, stalls randomly except in quiet stretches
  // in which bits 9:8 of its cycle counter are zero.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_answer(out_data);
      rx_cycle <= rx_cycle + 1;
      out_ready <= (rx_cycle[9:8] == 2'd0) || ($urandom_range(0, 3) != 0);
    end
  end

  // Sender: bursts of random length separated by random gaps. Valid stays high
  // across back-to-back transfers; it drops only at the start of a gap or when draining.
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = (gap == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, int unsigned v);
    cfg_valid <= 1'b1;
    cfg_data <= '{index: idx, data: v[12:0]};
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
  endtask

  task automatic set_config(int unsigned w, int unsigned h, int unsigned c, int unsigned r,
                            int unsigned rad);
    write_reg(REG_DISP_W, w);
    write_reg(REG_DISP_H, h);
    write_reg(REG_COLS, c);
    write_reg(REG_ROWS, r);
    write_reg(REG_RADIUS, rad);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t make_item(action_t a);
    in_item_t it;
    it = noise_item();
    it.action = a;
    return it;
  endfunction

  task automatic send_rect(action_t a, int unsigned x0, int unsigned y0, int unsigned x1,
                           int unsigned y1);
    in_item_t it;
    it = make_item(a);
    it.rect_x0 = 16'(x0);
    it.rect_y0 = 16'(y0);
    it.rect_x1 = 16'(x1);
    it.rect_y1 = 16'(y1);
    send_item(it);
  endtask

  task automatic send_frame(int unsigned n);
    in_item_t it;
    it = make_item(ACT_FRAME);
    it.win_count = 8'(n);
    send_item(it);
  endtask

  task automatic send_window(int x, int y, int unsigned w, int unsigned h,
                             int unsigned lyr, bit vis);
    in_item_t it;
    it = make_item(ACT_WINDOW);
    it.win_x = 16'(x);
    it.win_y = 16'(y);
    it.win_width = 16'(w);
    it.win_height = 16'(h);
    it.layer = 8'(lyr);
    it.visible = vis;
    send_item(it);
  endtask

  // Rectangle mostly inside the display, now and then anywhere.
  task automatic send_screen_rect(action_t a);
    int unsigned w, h, x0, y0;
    if ($urandom_range(0, 9) == 0) begin
      send_rect(a, $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535));
    end else begin
      w = sb.disp_w + 64;
      h = sb.disp_h + 64;
      x0 = $urandom_range(0, w);
      y0 = $urandom_range(0, h);
      send_rect(a, x0, y0, x0 + $urandom_range(0, w / 2 + 8), y0 + $urandom_range(0, h / 2 + 8));
    end
  endtask

  // One well-formed frame with random content, with a sprinkle of noise.
  // Every phase begins with a frame start, so a query never sees tiles
  // left over from a different tile grid.
  task automatic random_frame();
    int unsigned nwin, w, h;
    nwin = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 40) : $urandom_range(0, 255);
    send_frame(nwin);
    repeat ($urandom_range(0, 10)) begin
      if ($urandom_range(0, 4) == 0)
        send_rect(ACT_DAMAGE, 0, 0, $urandom_range(900, 4096), $urandom_range(900, 4096));
      else
        send_screen_rect(ACT_DAMAGE);
    end
    if ($urandom_range(0, 19) == 0) send_item(noise_item());
    send_item(make_item(ACT_GATE));
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 14) == 0) begin
        send_item(make_item(ACT_WINDOW));
      end else begin
        w = sb.disp_w + 64;
        h = sb.disp_h + 64;
        send_window(int'($urandom_range(0, w)) - 64, int'($urandom_range(0, h)) - 64,
                    $urandom_range(0, w), $urandom_range(0, h),
                    $urandom_range(0, nwin + 2), $urandom_range(0, 9) != 0);
      end
    end
    if ($urandom_range(0, 9) != 0) send_item(make_item(ACT_FINISH));
    if ($urandom_range(0, 19) == 0) send_item(noise_item());
    repeat ($urandom_range(1, 6)) send_screen_rect(ACT_QUERY);
  endtask

  task automatic random_phase(int budget);
    int start_count;
    start_count = sent;
    while (sent - start_count < budget) random_frame();
    drain();
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass at the reset register values.
    send_item(make_item(action_t'(3'd6)));            // unused codes
    send_item(make_item(action_t'(3'd7)));
    send_rect(ACT_QUERY, 0, 0, 100, 100);             // map not built yet
    send_frame(0);
    send_rect(ACT_DAMAGE, 0, 0, 65535, 65535);
    send_item(make_item(ACT_GATE));                   // too few windows
    send_frame(4);
    send_rect(ACT_DAMAGE, 0, 0, 1024, 1024);          // large-area path, low score
    send_item(make_item(ACT_GATE));
    send_item(make_item(ACT_FINISH));
    send_frame(255);
    send_rect(ACT_DAMAGE, 10, 10, 10, 20);            // empty rect still counts
    send_item(make_item(ACT_GATE));
    send_window(0, 0, 1024, 768, 0, 1'b0);            // invisible
    send_window(0, 0, 1024, 768, 255, 1'b1);          // reserved layer
    send_window(0, 0, 16, 768, 1, 1'b1);              // no body left after inset
    send_window(-32768, -32768, 65535, 65535, 200, 1'b1);
    send_window(-8, -8, 530, 400, 3, 1'b1);
    send_window(992, 760, 40, 40, 254, 1'b1);         // at the display edge; covers no tile
    send_item(make_item(ACT_FINISH));
    send_item(make_item(ACT_FINISH));
    send_rect(ACT_QUERY, 0, 0, 65535, 65535);
    send_rect(ACT_QUERY, 0, 0, 100, 100);
    send_rect(ACT_QUERY, 50, 50, 50, 60);             // empty bounds
    send_rect(ACT_QUERY, 65535, 0, 65535, 10);
    drain();

    random_phase(170);
    set_config(4096, 4096, 128, 128, 255);            // largest grid, few items
    random_phase(12);
    set_config(0, 0, 0, 0, 0);
    random_phase(35);
    set_config(200, 150, 8, 6, 3);
    random_phase(125);
    set_config(4096, 4096, 16, 16, 0);
    random_phase(100);
    set_config(512, 4096, 1, 128, 40);
    random_phase(25);
    set_config(300, 300, 20, 20, 1);
    random_phase(85);

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
